// File: hw/rtl/url_path_normalizer_top_assert.svh
// ----------------------------------------------------------------------------
// URL path normaliser assertion macros
// Shared assertion forms for the checker of the path normaliser.
// ----------------------------------------------------------------------------
`ifndef URL_PATH_NORMALIZER_TOP_ASSERT_SVH
`define URL_PATH_NORMALIZER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define UPN_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("upn check failed");

// The consequent must hold in the cycle after the antecedent.
`define UPN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("upn check failed");

`endif

// File: hw/rtl/upn_pkg.sv
// ----------------------------------------------------------------------------
// URL path normaliser package
// Character codes, status codes, beat kinds, parse phases and the path character test.
// ----------------------------------------------------------------------------
package upn_pkg;

	localparam logic [7:0] CH_SLASH      = 8'h2F;
	localparam logic [7:0] CH_DOT        = 8'h2E;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
	localparam logic [7:0] CH_DASH       = 8'h2D;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_ESCAPE = 2'd1;
	localparam logic [1:0] ST_TRUNC  = 2'd2;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef enum logic [1:0] {
		PH_PARSING = 2'd0,
		PH_DONE    = 2'd1
	} phase_t;

	function automatic logic is_path_char(input logic [7:0] c);
		logic lower;
		logic upper;
		logic digit;
		lower = (c >= 8'h61) && (c <= 8'h7A);
		upper = (c >= 8'h41) && (c <= 8'h5A);
		digit = (c >= 8'h30) && (c <= 8'h39);
		return lower || upper || digit || (c == CH_UNDERSCORE) || (c == CH_DASH)
			|| (c == CH_DOT);
	endfunction

endpackage

// File: hw/rtl/upn_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered, enabled read.
// ----------------------------------------------------------------------------
module upn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: hw/rtl/url_path_normalizer_top.sv
// ----------------------------------------------------------------------------
// URL path normaliser, top level
// A result beat is presented in the cycle after its beat is accepted.
// Throughput: one beat per cycle while the output is empty or taken; the component end stack is read a beat ahead.
// Reset clears the parser to the root path; the stores hold no reset state.
// ----------------------------------------------------------------------------
module url_path_normalizer_top #(
	parameter int PATH_BYTES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // data_byte[7:0], read_index[17:8], zero fill
	input  logic        s_tuser,   // kind
	input  logic        s_tlast,   // end_of_buffer
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // status[1:0], path_length[12:2], path_byte[20:13], zero fill
	output logic        m_tuser    // is_read_reply
);

	localparam int AW     = $clog2(PATH_BYTES);
	localparam int PW     = $clog2(PATH_BYTES + 4);
	localparam int SD     = PATH_BYTES / 2;
	localparam int SAW    = $clog2(SD);
	localparam int DW     = $clog2(SD + 1);
	localparam int WP_CAP = PATH_BYTES + 3;

	logic [7:0]  data_byte;
	logic [9:0]  read_index;
	logic        s_acc;
	logic        byte_acc;
	logic        rd_acc;

	upn_pkg::phase_t phase_q, phase_d;
	logic [PW-1:0] wp_q, wp_d;
	logic [PW-1:0] cl_q, cl_d;
	logic [DW-1:0] depth_q, depth_d;
	logic          dots_q, dots_d;
	logic          ovf_q, ovf_d;

	logic          parsing;
	logic          wp_lt_pb;
	logic [PW-1:0] clen;
	logic          fail;
	logic          emit;
	logic [1:0]    emit_status;
	logic [PW-1:0] emit_len;

	logic          pst_we;
	logic [7:0]    pst_wdata;
	logic [7:0]    pst_rdata;
	logic          stk_we;
	logic [PW-1:0] stk_rdata;

	logic          out_valid_s1;
	logic          is_read_s1;
	logic [1:0]    status_s1;
	logic [10:0]   len_s1;
	logic          rd_zero_s1;
	logic          rd_root_s1;
	logic [7:0]    path_byte;

	assign data_byte  = s_tdata[7:0];
	assign read_index = s_tdata[17:8];

	assign s_tready = !out_valid_s1 || m_tready;
	assign s_acc    = s_tvalid && s_tready;
	assign byte_acc = s_acc && (s_tuser == upn_pkg::KIND_BYTE);
	assign rd_acc   = s_acc && (s_tuser == upn_pkg::KIND_READ);

	assign wp_lt_pb = wp_q < PW'(PATH_BYTES);
	assign clen     = wp_q - cl_q;

	upn_ram #(
		.WIDTH(8),
		.DEPTH(PATH_BYTES)
	) u_path_store (
		.clk  (clk),
		.we   (pst_we),
		.waddr(AW'(wp_q)),
		.wdata(pst_wdata),
		.re   (rd_acc),
		.raddr(AW'(read_index)),
		.rdata(pst_rdata)
	);

	// The entry below the top is read continuously, so a pop finds it ready.
	upn_ram #(
		.WIDTH(PW),
		.DEPTH(SD)
	) u_stack (
		.clk  (clk),
		.we   (stk_we),
		.waddr(SAW'(depth_q)),
		.wdata(wp_q + PW'(1)),
		.re   (1'b1),
		.raddr(SAW'(depth_q - DW'(2))),
		.rdata(stk_rdata)
	);

	always_comb begin
		wp_d        = wp_q;
		cl_d        = cl_q;
		depth_d     = depth_q;
		dots_d      = dots_q;
		ovf_d       = ovf_q;
		fail        = 1'b0;
		emit        = 1'b0;
		emit_status = upn_pkg::ST_OK;
		emit_len    = '0;
		pst_we      = 1'b0;
		pst_wdata   = data_byte;
		stk_we      = 1'b0;
		if (byte_acc && parsing) begin
			if (upn_pkg::is_path_char(data_byte)) begin
				if (wp_lt_pb) begin
					pst_we = 1'b1;
				end else begin
					ovf_d = 1'b1;
				end
				if (wp_q < PW'(WP_CAP)) begin
					wp_d = wp_q + PW'(1);
				end
				if (data_byte != upn_pkg::CH_DOT) begin
					dots_d = 1'b0;
				end
				if (s_tlast) begin
					emit        = 1'b1;
					emit_status = upn_pkg::ST_TRUNC;
					emit_len    = cl_q;
				end
			end else begin
				if ((clen == '0) || (dots_q && (clen == PW'(1)))) begin
					cl_d = cl_q;
				end else if (dots_q && (clen == PW'(2))) begin
					if (depth_q == '0) begin
						fail        = 1'b1;
						emit        = 1'b1;
						emit_status = upn_pkg::ST_ESCAPE;
						emit_len    = '0;
					end else begin
						depth_d = depth_q - DW'(1);
						cl_d    = (depth_q == DW'(1)) ? PW'(1) : stk_rdata;
					end
				end else if (ovf_q || !wp_lt_pb || (depth_q >= DW'(SD))) begin
					fail        = 1'b1;
					emit        = 1'b1;
					emit_status = upn_pkg::ST_TRUNC;
					emit_len    = cl_q;
				end else begin
					pst_we    = 1'b1;
					pst_wdata = upn_pkg::CH_SLASH;
					stk_we    = 1'b1;
					cl_d      = wp_q + PW'(1);
					depth_d   = depth_q + DW'(1);
				end
				if (!fail) begin
					wp_d   = cl_d;
					dots_d = 1'b1;
					ovf_d  = 1'b0;
					if ((data_byte != upn_pkg::CH_SLASH) || s_tlast) begin
						emit        = 1'b1;
						emit_status = upn_pkg::ST_OK;
						emit_len    = cl_d - PW'(1);
					end
				end
			end
		end
		if (byte_acc && s_tlast) begin
			wp_d    = PW'(1);
			cl_d    = PW'(1);
			depth_d = '0;
			dots_d  = 1'b1;
			ovf_d   = 1'b0;
		end
	end

	always_comb begin
		phase_d = phase_q;
		if (byte_acc) begin
			if (s_tlast) begin
				phase_d = upn_pkg::PH_PARSING;
			end else if (emit) begin
				phase_d = upn_pkg::PH_DONE;
			end
		end
	end

	always_comb begin
		parsing = (phase_q == upn_pkg::PH_PARSING);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= upn_pkg::PH_PARSING;
			wp_q    <= PW'(1);
			cl_q    <= PW'(1);
			depth_q <= '0;
			dots_q  <= 1'b1;
			ovf_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			wp_q    <= wp_d;
			cl_q    <= cl_d;
			depth_q <= depth_d;
			dots_q  <= dots_d;
			ovf_q   <= ovf_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			out_valid_s1 <= rd_acc || emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && (rd_acc || emit)) begin
			is_read_s1 <= rd_acc;
			status_s1  <= rd_acc ? upn_pkg::ST_OK : emit_status;
			len_s1     <= rd_acc ? 11'd0 : 11'(emit_len);
			rd_zero_s1 <= !rd_acc || !(32'(read_index) < PATH_BYTES);
			rd_root_s1 <= read_index == 10'd0;
		end
	end

	// Index zero is never written; a read of it returns the root slash.
	assign path_byte = rd_zero_s1 ? 8'd0 : (rd_root_s1 ? upn_pkg::CH_SLASH : pst_rdata);

	assign m_tvalid = out_valid_s1;
	assign m_tuser  = is_read_s1;
	assign m_tdata  = {3'b000, path_byte, len_s1, status_s1};

endmodule

// File: hw/rtl/upn_checker.sv
// ----------------------------------------------------------------------------
// URL path normaliser port checker
// Watches the stream ports of the top level and flags impossible results.
// ----------------------------------------------------------------------------
`include "url_path_normalizer_top_assert.svh"

module upn_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [23:0] s_tdata,
	input logic        s_tuser,
	input logic        s_tlast,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tuser
);

	logic read_acc;
	logic parse_beat;

	assign read_acc   = s_tvalid && s_tready && (s_tuser == upn_pkg::KIND_READ);
	assign parse_beat = m_tvalid && (m_tuser == 1'b0);

	`UPN_ASSERT_NEXT(a_stall_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`UPN_ASSERT_NEXT(a_read_reply, clk, arst_n, read_acc, m_tvalid && m_tuser && (m_tdata[12:0] == 13'd0))
	`UPN_ASSERT_SAME(a_escape_len, clk, arst_n, parse_beat && (m_tdata[1:0] == upn_pkg::ST_ESCAPE), (m_tdata[12:2] == 11'd0) && (m_tdata[20:13] == 8'd0))
	`UPN_ASSERT_SAME(a_ready_free, clk, arst_n, !m_tvalid, s_tready)

endmodule

bind url_path_normalizer_top upn_checker u_upn_checker (.*);
